/* hw/rtl/vfeg_pkg.sv */
package vfeg_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned VAL_OUT_W   = 8;
  localparam int unsigned VAL_MAX_W   = 16;
  localparam int unsigned DIR_W       = 3;
  localparam int unsigned MASK_W      = 6;
  localparam int unsigned NUM_DIRS    = 6;
  // fixed-point shift for the reciprocal divide, idx < 2**RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 13;

  localparam int unsigned DEF_SIZE_X     = 16;
  localparam int unsigned DEF_SIZE_Y     = 16;
  localparam int unsigned DEF_SIZE_Z     = 16;
  localparam int unsigned DEF_VALUE_BITS = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

  function automatic logic [DIR_W-1:0] opposite_dir(input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] r;
    if (d < DIR_NX) begin
      r = d + DIR_NX;
    end else begin
      r = d - DIR_NX;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/vfeg_in_if.sv */
interface vfeg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [vfeg_pkg::IDX_W-1:0]     cell_index;
  logic [vfeg_pkg::VAL_OUT_W-1:0] block_value;
  logic [vfeg_pkg::DIR_W-1:0]     direction;

  modport source (output valid, opcode, cell_index, block_value, direction, input ready);
  modport sink   (input valid, opcode, cell_index, block_value, direction, output ready);
endinterface

/* hw/rtl/vfeg_out_if.sv */
interface vfeg_out_if;
  logic                          valid;
  logic                          ready;
  logic [vfeg_pkg::VAL_OUT_W-1:0] stored_value;
  logic [vfeg_pkg::MASK_W-1:0]    face_mask;
  logic                          face_exposed;

  modport source (output valid, stored_value, face_mask, face_exposed, input ready);
  modport sink   (input valid, stored_value, face_mask, face_exposed, output ready);
endinterface

/* hw/rtl/vfeg_nbr_decode.sv */
module vfeg_nbr_decode #(
  parameter int unsigned SIZE_X = vfeg_pkg::DEF_SIZE_X,
  parameter int unsigned SIZE_Y = vfeg_pkg::DEF_SIZE_Y,
  parameter int unsigned SIZE_Z = vfeg_pkg::DEF_SIZE_Z
) (
  input  logic                           clk,
  input  logic [vfeg_pkg::IDX_W-1:0]     idx,
  output logic [vfeg_pkg::NUM_DIRS-1:0]  nb_ok
);

  localparam int unsigned IDX_W  = vfeg_pkg::IDX_W;
  localparam int unsigned SHIFT  = vfeg_pkg::RECIP_SHIFT;
  localparam int unsigned LAYER  = SIZE_X * SIZE_Y;
  localparam int unsigned MX     = (1 << SHIFT) / SIZE_X;
  localparam int unsigned ML     = (1 << SHIFT) / LAYER;
  localparam int unsigned PROD_W = IDX_W + SHIFT;
  localparam int unsigned CW     = IDX_W + 1;

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_l;

  // stage 1: estimated quotients, may be one short
  logic [IDX_W-1:0] idx1_r;
  logic [IDX_W-1:0] qa0_r;
  logic [IDX_W-1:0] qz0_r;
  // stage 2: residues
  logic [IDX_W-1:0] qa0_2_r;
  logic [IDX_W-1:0] qz0_2_r;
  logic [CW-1:0]    ra_r;
  logic [CW-1:0]    rz_r;
  // stage 3: corrected quotients
  logic [IDX_W-1:0] qa_r;
  logic [IDX_W-1:0] x3_r;
  logic [IDX_W-1:0] z3_r;
  // stage 4: coordinates
  logic [IDX_W-1:0] x4_r;
  logic [IDX_W-1:0] y4_r;
  logic [IDX_W-1:0] z4_r;

  assign prod_x = PROD_W'(idx) * PROD_W'(MX);
  assign prod_l = PROD_W'(idx) * PROD_W'(ML);

  always_ff @(posedge clk) begin
    idx1_r  <= idx;
    qa0_r   <= prod_x[PROD_W-1:SHIFT];
    qz0_r   <= prod_l[PROD_W-1:SHIFT];

    qa0_2_r <= qa0_r;
    qz0_2_r <= qz0_r;
    ra_r    <= CW'(idx1_r) - CW'(qa0_r) * CW'(SIZE_X);
    rz_r    <= CW'(idx1_r) - CW'(qz0_r) * CW'(LAYER);

    if (ra_r >= CW'(SIZE_X)) begin
      qa_r <= qa0_2_r + IDX_W'(1);
      x3_r <= IDX_W'(ra_r - CW'(SIZE_X));
    end else begin
      qa_r <= qa0_2_r;
      x3_r <= IDX_W'(ra_r);
    end
    if (rz_r >= CW'(LAYER)) begin
      z3_r <= qz0_2_r + IDX_W'(1);
    end else begin
      z3_r <= qz0_2_r;
    end

    x4_r <= x3_r;
    y4_r <= qa_r - z3_r * IDX_W'(SIZE_Y);
    z4_r <= z3_r;
  end

  always_comb begin
    nb_ok[vfeg_pkg::DIR_PX] = (x4_r != IDX_W'(SIZE_X - 1));
    nb_ok[vfeg_pkg::DIR_PY] = (y4_r != IDX_W'(SIZE_Y - 1));
    nb_ok[vfeg_pkg::DIR_PZ] = (z4_r != IDX_W'(SIZE_Z - 1));
    nb_ok[vfeg_pkg::DIR_NX] = (x4_r != '0);
    nb_ok[vfeg_pkg::DIR_NY] = (y4_r != '0);
    nb_ok[vfeg_pkg::DIR_NZ] = (z4_r != '0);
  end

endmodule

/* hw/rtl/voxel_face_exposure_grid_top.sv */
// channel   port      dir  fields
// input     in_item   in   opcode, cell_index, block_value, direction
// result    out_item  out  stored_value, face_mask, face_exposed
//
// read: returns the stored value and face mask of the cell; write: steps through the six
// neighbour visits using the one read port and one write port of each memory.
// an index outside the grid gives a zero result.
// after reset the memories are swept to zero, one cell a cycle over all SIZE_X*SIZE_Y*SIZE_Z
// cells, with in_item.ready low.
// one item at a time; a finished result waits in the output register while the
// next item is taken, and a further result waits until that register is free.
module voxel_face_exposure_grid_top #(
  parameter int unsigned SIZE_X     = vfeg_pkg::DEF_SIZE_X,
  parameter int unsigned SIZE_Y     = vfeg_pkg::DEF_SIZE_Y,
  parameter int unsigned SIZE_Z     = vfeg_pkg::DEF_SIZE_Z,
  parameter int unsigned VALUE_BITS = vfeg_pkg::DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  vfeg_in_if.sink      in_item,
  vfeg_out_if.source   out_item
);

  localparam int unsigned IDX_W     = vfeg_pkg::IDX_W;
  localparam int unsigned DIR_W     = vfeg_pkg::DIR_W;
  localparam int unsigned MASK_W    = vfeg_pkg::MASK_W;
  localparam int unsigned OUT_W     = vfeg_pkg::VAL_OUT_W;
  localparam int unsigned VMAX_W    = vfeg_pkg::VAL_MAX_W;
  localparam int unsigned NUM_DIRS  = vfeg_pkg::NUM_DIRS;
  localparam int unsigned LAYER     = SIZE_X * SIZE_Y;
  localparam int unsigned CELLS     = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned DEC_LAST  = 3;

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DEC    = 3'd2;
  localparam logic [2:0] ST_RDRESP = 3'd3;
  localparam logic [2:0] ST_LOOP   = 3'd4;
  localparam logic [2:0] ST_WB     = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [VALUE_BITS-1:0] blk_mem  [CELLS];
  logic [MASK_W-1:0]     face_mem [CELLS];

  logic [2:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  op_r, op_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [DIR_W-1:0]      dir_r, dir_nxt;
  logic [MASK_W-1:0]     own_mask_r, own_mask_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [DIR_W-1:0]      pend_dir_r, pend_dir_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [OUT_W-1:0]      res_val_r, res_val_nxt;
  logic [MASK_W-1:0]     res_mask_r, res_mask_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_val_r, out_val_nxt;
  logic [MASK_W-1:0]     out_mask_r, out_mask_nxt;
  logic                  out_exp_r, out_exp_nxt;

  logic [VALUE_BITS-1:0] blk_rd_r;
  logic [MASK_W-1:0]     face_rd_r;

  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic                  blk_we;
  logic [ADDR_W-1:0]     blk_waddr;
  logic [VALUE_BITS-1:0] blk_wdata;
  logic                  face_we;
  logic [ADDR_W-1:0]     face_waddr;
  logic [MASK_W-1:0]     face_wdata;
  logic                  load_out;

  logic [NUM_DIRS-1:0]   nb_ok;
  logic [ADDR_W-1:0]     nb_addr;
  logic                  accept;
  logic [31:0]           in_idx_ext;
  logic [VMAX_W-1:0]     in_val_ext;
  logic [VMAX_W-1:0]     blk_rd_ext;
  logic [VMAX_W-1:0]     val_ext;
  logic                  solid;
  logic [DIR_W-1:0]      pend_opp;

  vfeg_nbr_decode #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_nbr_decode (
    .clk   (clk),
    .idx   (idx_r),
    .nb_ok (nb_ok)
  );

  assign accept         = in_item.valid && in_item.ready;
  assign in_item.ready  = (state_r == ST_IDLE);
  assign in_idx_ext     = 32'(in_item.cell_index);
  assign in_val_ext     = VMAX_W'(in_item.block_value);
  assign blk_rd_ext     = VMAX_W'(blk_rd_r);
  assign val_ext        = VMAX_W'(val_r);
  assign solid          = (val_r != '0);
  assign pend_opp       = vfeg_pkg::opposite_dir(pend_dir_r);

  assign out_item.valid        = out_valid_r;
  assign out_item.stored_value = out_val_r;
  assign out_item.face_mask    = out_mask_r;
  assign out_item.face_exposed = out_exp_r;

  always_comb begin
    unique case (step_r)
      vfeg_pkg::DIR_PX: nb_addr = addr_r + ADDR_W'(1);
      vfeg_pkg::DIR_PY: nb_addr = addr_r + ADDR_W'(SIZE_X);
      vfeg_pkg::DIR_PZ: nb_addr = addr_r + ADDR_W'(LAYER);
      vfeg_pkg::DIR_NX: nb_addr = addr_r - ADDR_W'(1);
      vfeg_pkg::DIR_NY: nb_addr = addr_r - ADDR_W'(SIZE_X);
      vfeg_pkg::DIR_NZ: nb_addr = addr_r - ADDR_W'(LAYER);
      default:          nb_addr = addr_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    step_nxt       = step_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    addr_nxt       = addr_r;
    val_nxt        = val_r;
    dir_nxt        = dir_r;
    own_mask_nxt   = own_mask_r;
    pend_valid_nxt = 1'b0;
    pend_dir_nxt   = pend_dir_r;
    pend_addr_nxt  = pend_addr_r;
    res_val_nxt    = res_val_r;
    res_mask_nxt   = res_mask_r;
    mem_re         = 1'b0;
    mem_raddr      = addr_r;
    blk_we         = 1'b0;
    blk_waddr      = addr_r;
    blk_wdata      = val_r;
    face_we        = 1'b0;
    face_waddr     = addr_r;
    face_wdata     = own_mask_r;
    load_out       = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        blk_we     = 1'b1;
        blk_waddr  = clr_r;
        blk_wdata  = '0;
        face_we    = 1'b1;
        face_waddr = clr_r;
        face_wdata = '0;
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_item.opcode;
          idx_nxt  = in_item.cell_index;
          addr_nxt = in_idx_ext[ADDR_W-1:0];
          val_nxt  = in_val_ext[VALUE_BITS-1:0];
          dir_nxt  = in_item.direction;
          step_nxt = '0;
          if (in_idx_ext < CELLS) begin
            state_nxt = ST_DEC;
          end else begin
            res_val_nxt  = '0;
            res_mask_nxt = '0;
            state_nxt    = ST_FIN;
          end
        end
      end
      ST_DEC: begin
        // own cell read goes out on the first cycle, coordinates settle meanwhile
        if (step_r == '0) begin
          mem_re = 1'b1;
        end
        if (step_r == STEP_W'(1)) begin
          own_mask_nxt = face_rd_r;
        end
        if (step_r == '0 && op_r == vfeg_pkg::OP_READ) begin
          state_nxt = ST_RDRESP;
        end else if (step_r == STEP_W'(DEC_LAST)) begin
          step_nxt  = '0;
          state_nxt = ST_LOOP;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_RDRESP: begin
        res_val_nxt  = blk_rd_ext[OUT_W-1:0];
        res_mask_nxt = face_rd_r;
        state_nxt    = ST_FIN;
      end
      ST_LOOP: begin
        // issue the read for this face while the previous face is resolved
        if (step_r < STEP_W'(NUM_DIRS)) begin
          if (nb_ok[step_r]) begin
            mem_re         = 1'b1;
            mem_raddr      = nb_addr;
            pend_valid_nxt = 1'b1;
            pend_dir_nxt   = step_r;
            pend_addr_nxt  = nb_addr;
          end else if (solid) begin
            own_mask_nxt = own_mask_nxt | (MASK_W'(1) << step_r);
          end
          step_nxt = step_r + STEP_W'(1);
        end else begin
          state_nxt = ST_WB;
        end
        if (pend_valid_r) begin
          face_waddr = pend_addr_r;
          if (!solid) begin
            face_we    = 1'b1;
            face_wdata = face_rd_r | (MASK_W'(1) << pend_opp);
          end else if (blk_rd_r == '0) begin
            own_mask_nxt = own_mask_nxt | (MASK_W'(1) << pend_dir_r);
          end else begin
            own_mask_nxt = own_mask_nxt & ~(MASK_W'(1) << pend_dir_r);
            face_we      = 1'b1;
            face_wdata   = face_rd_r & ~(MASK_W'(1) << pend_opp);
          end
        end
      end
      ST_WB: begin
        // an air cell writes back its unchanged mask
        blk_we       = 1'b1;
        face_we      = 1'b1;
        res_val_nxt  = val_ext[OUT_W-1:0];
        res_mask_nxt = own_mask_r;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_item.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_val_nxt   = out_val_r;
    out_mask_nxt  = out_mask_r;
    out_exp_nxt   = out_exp_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_mask_nxt  = res_mask_r;
      out_exp_nxt   = (dir_r <= vfeg_pkg::DIR_NZ) ? res_mask_r[dir_r] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (mem_re) begin
      blk_rd_r <= blk_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (face_we) begin
      face_mem[face_waddr] <= face_wdata;
    end
    if (mem_re) begin
      face_rd_r <= face_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      step_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      step_r       <= step_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    addr_r      <= addr_nxt;
    val_r       <= val_nxt;
    dir_r       <= dir_nxt;
    own_mask_r  <= own_mask_nxt;
    pend_dir_r  <= pend_dir_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_val_r   <= res_val_nxt;
    res_mask_r  <= res_mask_nxt;
    out_val_r   <= out_val_nxt;
    out_mask_r  <= out_mask_nxt;
    out_exp_r   <= out_exp_nxt;
  end

endmodule
